FILE: hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths, types and command/status structs for the cosine engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int ACC_W      = 44;
    localparam int ROOT_W     = 22;
    localparam int DEN_W      = 44;
    localparam int NUM_W      = 58;
    localparam int Q_W        = 15;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int FRAC_OUT   = 14;
    localparam logic [Q_W-1:0] ONE_OUT = 15'd16384;

    typedef struct packed {
        logic accumulate;
        logic start_sqrt;
        logic sqrt_step;
        logic mult;
        logic start_div;
        logic div_step;
        logic finish;
        logic clear;
    } cse_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic degenerate;
    } cse_status_t;

endpackage

FILE: hw/rtl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Cosine similarity of two streamed vectors in Q2.14.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle while the block accumulates. After
// the pair marked last, the block works out the result in order: a setup
// state, two 22-step square roots in parallel, the root product, a divider
// setup state, a 58-step restoring divider and a final load of the result
// register. Input is held off until that result is taken.
module cosine_similarity_engine
    import cse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // a_elem [15:0], b_elem [31:16]
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // similarity [15:0]
    output logic        m_tuser,   // degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [CFG_W-1:0] min_den_reg;
    cse_cmd_t         cmd;
    cse_status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_den_reg <= 16'd2;
        else if (cfg_valid)
            min_den_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    cse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_tvalid && s_tready),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    cse_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .a_elem          (s_tdata[ELEM_WIDTH-1:0]),
        .b_elem          (s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
        .min_denominator (min_den_reg),
        .cmd             (cmd),
        .status          (status),
        .similarity      (m_tdata),
        .degenerate      (m_tuser)
    );

endmodule

FILE: hw/rtl/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// Saturating accumulators, two-bit-per-step square roots, root product and
// one-bit-per-step restoring divider.
// ----------------------------------------------------------------------------
module cse_datapath
    import cse_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ELEM_WIDTH-1:0] a_elem,
    input  logic signed [ELEM_WIDTH-1:0] b_elem,
    input  logic [CFG_W-1:0]             min_denominator,
    input  cse_cmd_t                     cmd,
    output cse_status_t                  status,
    output logic [OUT_W-1:0]             similarity,
    output logic                         degenerate
);

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam logic signed [ACC_W+1:0] ACC_MAX = (46'sd1 <<< (ACC_W - 1)) - 46'sd1;
    localparam logic signed [ACC_W+1:0] ACC_MIN = -(46'sd1 <<< (ACC_W - 1));

    logic signed [ACC_W-1:0] dot_reg, dot_next;
    logic signed [ACC_W-1:0] asq_reg, asq_next;
    logic signed [ACC_W-1:0] bsq_reg, bsq_next;

    logic [ACC_W-1:0]  ax_reg, bx_reg;
    logic [ROOT_W-1:0] ar_reg, br_reg;
    logic [4:0]        step_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W:0]    rem_reg;
    logic              neg_reg;
    logic [5:0]        dstep_reg;
    logic [OUT_W-1:0]  sim_reg;
    logic              degen_reg;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [PROD_W-1:0] term
    );
        logic signed [ACC_W+1:0] s;
        begin
            s = {{2{acc[ACC_W-1]}}, acc} + (ACC_W + 2)'(term);
            if (s > ACC_MAX)
                sat_add = ACC_MAX[ACC_W-1:0];
            else if (s < ACC_MIN)
                sat_add = ACC_MIN[ACC_W-1:0];
            else
                sat_add = s[ACC_W-1:0];
        end
    endfunction

    // One iteration: bring down two radicand bits, try root*4+1.
    function automatic logic [ACC_W+ROOT_W-1:0] sqrt_iter(
        input logic [ACC_W-1:0]  x,
        input logic [ROOT_W-1:0] r,
        input logic [ACC_W-1:0]  remv
    );
        logic [ROOT_W+2:0] rem_w;
        logic [ROOT_W+2:0] trial;
        begin
            rem_w = {remv[ROOT_W:0], x[ACC_W-1:ACC_W-2]};
            trial = {1'b0, r, 2'b01};
            if (rem_w >= trial)
                sqrt_iter = {ACC_W'(rem_w - trial), r[ROOT_W-2:0], 1'b1};
            else
                sqrt_iter = {ACC_W'(rem_w), r[ROOT_W-2:0], 1'b0};
        end
    endfunction

    logic [ACC_W-1:0] arem_reg, brem_reg;
    logic [ACC_W+ROOT_W-1:0] a_it, b_it;
    logic signed [PROD_W-1:0] pab, paa, pbb;
    logic [DEN_W:0] rem_sh;
    logic [ACC_W-1:0] dot_mag;

    assign a_it = sqrt_iter(ax_reg, ar_reg, arem_reg);
    assign b_it = sqrt_iter(bx_reg, br_reg, brem_reg);
    assign pab = a_elem * b_elem;
    assign paa = a_elem * a_elem;
    assign pbb = b_elem * b_elem;
    assign rem_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign dot_mag = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : dot_reg;

    always_comb
    begin
        dot_next = dot_reg;
        asq_next = asq_reg;
        bsq_next = bsq_reg;
        if (cmd.clear)
        begin
            dot_next = '0;
            asq_next = '0;
            bsq_next = '0;
        end
        else if (cmd.accumulate)
        begin
            dot_next = sat_add(dot_reg, pab);
            asq_next = sat_add(asq_reg, paa);
            bsq_next = sat_add(bsq_reg, pbb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            asq_reg   <= '0;
            bsq_reg   <= '0;
            step_reg  <= '0;
            dstep_reg <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            asq_reg <= asq_next;
            bsq_reg <= bsq_next;
            if (cmd.start_sqrt)
                step_reg <= '0;
            else if (cmd.sqrt_step)
                step_reg <= step_reg + 5'd1;
            if (cmd.start_div)
                dstep_reg <= '0;
            else if (cmd.div_step)
                dstep_reg <= dstep_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sqrt)
        begin
            ax_reg   <= asq_reg;
            bx_reg   <= bsq_reg;
            ar_reg   <= '0;
            br_reg   <= '0;
            arem_reg <= '0;
            brem_reg <= '0;
            neg_reg  <= dot_reg[ACC_W-1];
            num_reg  <= {dot_mag, {FRAC_OUT{1'b0}}};
        end
        else if (cmd.sqrt_step)
        begin
            ax_reg   <= {ax_reg[ACC_W-3:0], 2'b00};
            bx_reg   <= {bx_reg[ACC_W-3:0], 2'b00};
            ar_reg   <= a_it[ROOT_W-1:0];
            br_reg   <= b_it[ROOT_W-1:0];
            arem_reg <= a_it[ACC_W+ROOT_W-1:ROOT_W];
            brem_reg <= b_it[ACC_W+ROOT_W-1:ROOT_W];
        end
        if (cmd.mult)
            den_reg <= ar_reg * br_reg;
        if (cmd.start_div)
        begin
            rem_reg   <= '0;
            degen_reg <= (den_reg <= DEN_W'(min_denominator));
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], (rem_sh >= {1'b0, den_reg})};
            if (rem_sh >= {1'b0, den_reg})
                rem_reg <= rem_sh - {1'b0, den_reg};
            else
                rem_reg <= rem_sh;
        end
        if (cmd.finish)
        begin
            if (degen_reg)
                sim_reg <= '0;
            else if (num_reg > NUM_W'(ONE_OUT))
                sim_reg <= neg_reg ? -OUT_W'(ONE_OUT) : OUT_W'(ONE_OUT);
            else
                sim_reg <= neg_reg ? -num_reg[OUT_W-1:0] : num_reg[OUT_W-1:0];
        end
    end

    assign status.sqrt_done  = (step_reg == 5'(ROOT_W - 1));
    assign status.div_done   = (dstep_reg == 6'(NUM_W - 1));
    assign status.degenerate = degen_reg;
    assign similarity = sim_reg;
    assign degenerate = degen_reg;

endmodule

FILE: hw/rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer: accumulate, square roots, product, divide, output hold.
// ----------------------------------------------------------------------------
module cse_ctrl
    import cse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        in_last,
    input  logic        out_ready,
    input  cse_status_t status,
    output cse_cmd_t    cmd,
    output logic        in_ready,
    output logic        out_valid
);

    typedef enum logic [7:0] {
        S_ACC   = 8'b00000001,
        S_SQRT0 = 8'b00000010,
        S_SQRT  = 8'b00000100,
        S_MULT  = 8'b00001000,
        S_DIV0  = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.accumulate = in_fire;
                if (in_fire && in_last)
                    state_next = S_SQRT0;
            end
            S_SQRT0:
            begin
                cmd.start_sqrt = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                    state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult  = 1'b1;
                cmd.clear = 1'b1;
                state_next = S_DIV0;
            end
            S_DIV0:
            begin
                cmd.start_div = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = S_FIN;
            end
            // quotient is complete here; load the result register
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_ACC;
            end
            default:
                state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_ACC;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = (state_reg == S_OUT);

endmodule

FILE: hw/rtl/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks for the cosine engine.
// ----------------------------------------------------------------------------
module cse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // Hold the result while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // Degenerate results carry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("degenerate result not zero");

    // Never accept input while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted during output");

    // A last transfer stops input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken after last");

endmodule

bind cosine_similarity_engine cse_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/tb_cosine_similarity_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity_engine
// Streams element pairs into the cosine engine with random gaps and output
// stalls, predicts each similarity result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine;
    import cse_pkg::*;

    typedef struct packed {
        logic signed [15:0] a_elem;
        logic signed [15:0] b_elem;
        logic               last;
    } elem_pair_t;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               degenerate;
    } sim_result_t;

    localparam longint SUM_MAX = (64'sd1 <<< 43) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< 43);

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    elem_pair_t  pending_pairs[$];
    sim_result_t expected_sims[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    logic   send_hold;
    int     mismatch_count;
    longint dot_acc;
    longint a_norm_acc;
    longint b_norm_acc;
    logic [15:0] threshold;

    cosine_similarity_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint sat_sum(longint acc, longint term);
        longint s;
        s = acc + term;
        if (s > SUM_MAX)
            return SUM_MAX;
        if (s < SUM_MIN)
            return SUM_MIN;
        return s;
    endfunction

    function automatic longint floor_root(longint x);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd4194304;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Accumulate one pair; on last, push the expected similarity and clear.
    task automatic predict_similarity(elem_pair_t p);
        longint      denom;
        longint      mag;
        longint      quot;
        sim_result_t r;
        dot_acc    = sat_sum(dot_acc, longint'(p.a_elem) * longint'(p.b_elem));
        a_norm_acc = sat_sum(a_norm_acc, longint'(p.a_elem) * longint'(p.a_elem));
        b_norm_acc = sat_sum(b_norm_acc, longint'(p.b_elem) * longint'(p.b_elem));
        if (p.last)
        begin
            denom = floor_root(a_norm_acc) * floor_root(b_norm_acc);
            r = '0;
            if (denom <= longint'(threshold))
                r.degenerate = 1'b1;
            else
            begin
                mag  = (dot_acc < 0) ? -dot_acc : dot_acc;
                quot = (mag <<< FRAC_OUT) / denom;
                if (quot > 16384)
                    quot = 16384;
                r.similarity = (dot_acc < 0) ? 16'(-quot) : 16'(quot);
            end
            expected_sims.push_back(r);
            dot_acc    = 0;
            a_norm_acc = 0;
            b_norm_acc = 0;
        end
    endtask

    // Driver: predict at the accepting edge so expectations precede results.
    // With send_hold set, hold off while any result is still outstanding.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_similarity(pending_pairs.pop_front());
            end
            if ((!s_tvalid || s_tready) && pending_pairs.size() > 0
                && $urandom_range(99) >= send_idle_pct
                && !(send_hold && expected_sims.size() > 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_pairs[0].b_elem, pending_pairs[0].a_elem};
                s_tlast  <= pending_pairs[0].last;
            end
            else if (!s_tvalid || s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // Monitor and output stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sims.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result sim=%0d degen=%0b",
                                 $signed(m_tdata), m_tuser);
                end
                else if (expected_sims[0].similarity !== m_tdata
                         || expected_sims[0].degenerate !== m_tuser)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected sim=%0d degen=%0b, got sim=%0d degen=%0b",
                                 expected_sims[0].similarity, expected_sims[0].degenerate,
                                 $signed(m_tdata), m_tuser);
                    void'(expected_sims.pop_front());
                end
                else
                    void'(expected_sims.pop_front());
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_pair(int a, int b, bit lst);
        elem_pair_t p;
        p.a_elem = 16'(a);
        p.b_elem = 16'(b);
        p.last   = lst;
        pending_pairs.push_back(p);
    endtask

    // Random vector; mostly short, sometimes long, some with small elements.
    task automatic queue_vector();
        int len;
        int kind;
        int a;
        int b;
        kind = $urandom_range(9);
        len  = (kind == 0) ? $urandom_range(200, 40) : $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
        begin
            a = $signed(16'($urandom));
            b = $signed(16'($urandom));
            if (kind == 1)
                b = a;
            else if (kind == 2)
                b = -a;
            else if (kind == 3)
            begin
                a = a >>> 12;
                b = b >>> 12;
            end
            queue_pair(a, b, i == len - 1);
        end
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || expected_sims.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        threshold = v;
        cfg_valid <= 1'b0;
    endtask

    // Queue whole vectors until about n_pairs pairs have been added.
    task automatic run_random(int n_pairs);
        int target;
        int qsize;
        target = n_pairs;
        while (target > 0)
        begin
            qsize = pending_pairs.size();
            queue_vector();
            target = target - (pending_pairs.size() - qsize);
            while (pending_pairs.size() > 20)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_hold      = 1'b0;
        send_idle_pct  = 7;
        recv_idle_pct  = 84;
        mismatch_count = 0;
        threshold      = 16'd2;
        dot_acc        = 0;
        a_norm_acc     = 0;
        b_norm_acc     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, degenerate zero vector, sign cases.
        queue_pair(0, 0, 1);
        queue_pair(32767, 32767, 1);
        queue_pair(-32768, 32767, 1);
        queue_pair(-32768, -32768, 1);
        queue_pair(1, 1, 1);
        queue_pair(2, 2, 1);
        queue_pair(4096, 0, 0);
        queue_pair(0, 4096, 1);
        queue_pair(4096, 4096, 0);
        queue_pair(-4096, 4096, 1);
        for (int i = 0; i < 9; i++)
            queue_pair(-32768, -32768, i == 8);
        queue_pair(100, -50, 0);
        queue_pair(-3, 7, 1);
        drain();

        // Sender holds after each vector until every result is back.
        send_hold = 1'b1;
        run_random(40);
        drain();
        send_hold = 1'b0;
        run_random(450);
        drain();

        write_threshold(16'd0);
        send_idle_pct = 84;
        recv_idle_pct = 7;
        queue_pair(1, 1, 1);
        queue_pair(0, 0, 1);
        run_random(450);
        drain();

        write_threshold(16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_pair(255, 255, 1);
        queue_pair(256, 256, 1);
        run_random(200);
        drain();

        write_threshold(16'($urandom));
        run_random(300);
        drain();

        if (mismatch_count == 0 && expected_sims.size() == 0)
            $display("tb_cosine_similarity_engine: done, clean");
        else
            $display("tb_cosine_similarity_engine: done, errors");
        $finish;
    end

    initial
    begin
        #(20ns * 2000000);
        $display("tb_cosine_similarity_engine: done, errors");
        $finish;
    end

endmodule
